// ----- hdl/iad_pkg.sv -----
// Package for the investment allocation dynamic-programming unit.
// Holds transaction payload types, cell control type, codes and widths.
// No dependencies.
package iad_pkg;

    localparam int PROFIT_W = 16;
    localparam int BEST_W   = 18;
    localparam int ALLOC_W  = 3;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_START = 1'b1
    } t_op;

    typedef enum logic {
        CFG_MONEY_LEVELS  = 1'b0,
        CFG_PROJECT_COUNT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_op                 operation;
        logic [1:0]          project_index;
        logic [2:0]          money_level;
        logic [PROFIT_W-1:0] profit_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         project_number;
        logic [ALLOC_W-1:0] allocation;
        logic [BEST_W-1:0]  total_profit;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic wr_prof;
        logic init;
        logic load;
        logic step;
        logic shift;
        logic commit;
    } t_cell_ctl;

endpackage

// ----- hdl/iad_in_if.sv -----
// Input channel of the allocation unit: valid, ready and one request item.
// Depends on iad_pkg.
interface iad_in_if;
    iad_pkg::t_in_item data;
    logic              valid;
    logic              ready;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/iad_out_if.sv -----
// Result channel of the allocation unit: valid, ready and one result item.
// Depends on iad_pkg.
interface iad_out_if;
    iad_pkg::t_out_item data;
    logic               valid;
    logic               ready;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/investment_allocation_dp_unit.sv -----
// Top level of the investment allocation dynamic-programming unit.
// Sequencer around a row of iad_cell instances. Depends on iad_pkg,
// iad_in_if, iad_out_if and iad_cell.
//
// Channel   Direction  Handshake      Payload
// i_in      in         valid/ready    t_in_item (load entry or start)
// o_res     out        valid/ready    t_out_item (one project per transaction)
// i_cfg_*   in         write enable   register index and 4-bit data
//
// A load writes one profit entry. A start runs an init state, then for each
// project after the first a load, recurrence steps of the cell row and a commit,
// then a level scan; it emits P results (P = project_count), one per cycle unless stalled.
// Input is held off from a start until its last result is in the output register.
// Reset is synchronous, active low, and clears control state only.
// A stalled result sink holds the sequencer in the backtrack phase.
module investment_allocation_dp_unit #(
    parameter int MAX_LEVELS   = 8,
    parameter int MAX_PROJECTS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iad_in_if.sink     i_in,
    iad_out_if.source  o_res,
    input  logic       i_cfg_we,
    input  iad_pkg::t_cfg_idx i_cfg_idx,
    input  logic [3:0] i_cfg_data
);
    import iad_pkg::*;

    localparam int LVW = $clog2(MAX_LEVELS);
    localparam int MW  = LVW + 1;
    localparam int PJW = (MAX_PROJECTS > 1) ? $clog2(MAX_PROJECTS) : 1;
    localparam int PW  = PJW + 1;
    localparam int LV_RST = (6 > MAX_LEVELS) ? MAX_LEVELS : 6;
    localparam int PJ_RST = (4 > MAX_PROJECTS) ? MAX_PROJECTS : 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_LOAD,
        S_STEP,
        S_COMMIT,
        S_SCAN,
        S_BACK
    } t_state;

    t_state          r_state;
    logic [MW-1:0]   r_levels;
    logic [PW-1:0]   r_projs;
    logic [PJW-1:0]  r_i;
    logic [LVW-1:0]  r_k;
    logic [BEST_W-1:0] r_top;
    logic [LVW-1:0]  r_level;
    logic [LVW-1:0]  r_left;
    logic [PW-1:0]   r_bi;
    logic            r_ovalid;
    t_out_item       r_odata;

    t_cell_ctl       w_ctl;
    logic [PJW-1:0]  w_proj;
    logic [PJW-1:0]  w_rd_proj;
    logic [LVW-1:0]  w_k_last;
    logic            w_load_ok;
    logic [BEST_W-1:0]   w_head;
    logic [ALLOC_W-1:0]  w_choice;
    logic [ALLOC_W-1:0]  w_alloc;
    logic [LVW-1:0]      w_level_nx;
    logic [BEST_W-1:0]   w_top_nx;
    logic            w_slot;

    logic [PROFIT_W-1:0] w_sh   [MAX_LEVELS+1];
    logic [BEST_W-1:0]   w_prev [MAX_LEVELS+1];
    logic [ALLOC_W-1:0]  w_ch   [MAX_LEVELS];

    assign w_k_last  = LVW'(r_levels - MW'(1));
    assign w_load_ok = (int'(i_in.data.project_index) < MAX_PROJECTS)
                    && (int'(i_in.data.money_level) < MAX_LEVELS);
    assign w_proj    = (r_state == S_IDLE) ? PJW'(i_in.data.project_index) : r_i;
    assign w_rd_proj = PJW'(r_bi - PW'(1));
    assign w_head    = w_prev[0];
    assign w_slot    = !r_ovalid || o_res.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_odata;

    always_comb begin
        w_ctl         = '0;
        w_ctl.wr_prof = (r_state == S_IDLE) && i_in.valid
                     && (i_in.data.operation == OP_LOAD) && w_load_ok;
        w_ctl.init    = (r_state == S_INIT);
        w_ctl.load    = (r_state == S_LOAD);
        w_ctl.step    = (r_state == S_STEP);
        w_ctl.shift   = (r_state == S_STEP) || (r_state == S_SCAN);
        w_ctl.commit  = (r_state == S_COMMIT);
    end

    always_comb begin
        w_choice = '0;
        for (int j = 0; j < MAX_LEVELS; j++) begin
            w_choice = w_choice | w_ch[j];
        end
    end

    always_comb begin
        if (int'(w_choice) > int'(r_left)) begin
            w_alloc = ALLOC_W'(r_left);
        end else begin
            w_alloc = w_choice;
        end
    end

    always_comb begin
        w_top_nx   = r_top;
        w_level_nx = r_level;
        if (w_head > r_top) begin
            w_top_nx   = w_head;
            w_level_nx = r_k;
        end
    end

    assign w_sh[0]            = '0;
    assign w_prev[MAX_LEVELS] = '0;

    for (genvar j = 0; j < MAX_LEVELS; j++) begin : g_cell
        iad_cell #(
            .MAX_PROJECTS (MAX_PROJECTS),
            .MAX_LEVELS   (MAX_LEVELS),
            .J            (j)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_proj    (w_proj),
            .i_rd_proj (w_rd_proj),
            .i_wr_lvl  (i_in.data.money_level),
            .i_wr_data (i_in.data.profit_value),
            .i_k       (r_k),
            .i_left    (r_left),
            .i_head    (w_head),
            .i_sh      (w_sh[j]),
            .o_sh      (w_sh[j+1]),
            .i_prev    (w_prev[j+1]),
            .o_prev    (w_prev[j]),
            .o_choice  (w_ch[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_levels <= MW'(LV_RST);
            r_projs  <= PW'(PJ_RST);
            r_ovalid <= 1'b0;
            r_i      <= '0;
            r_k      <= '0;
            r_bi     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MONEY_LEVELS: begin
                        if (i_cfg_data == 4'd0) begin
                            r_levels <= MW'(1);
                        end else if (int'(i_cfg_data) > MAX_LEVELS) begin
                            r_levels <= MW'(MAX_LEVELS);
                        end else begin
                            r_levels <= MW'(i_cfg_data);
                        end
                    end
                    CFG_PROJECT_COUNT: begin
                        if (i_cfg_data[2:0] == 3'd0) begin
                            r_projs <= PW'(1);
                        end else if (int'(i_cfg_data[2:0]) > MAX_PROJECTS) begin
                            r_projs <= PW'(MAX_PROJECTS);
                        end else begin
                            r_projs <= PW'(i_cfg_data[2:0]);
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if ((r_state == S_BACK) && w_slot) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && (i_in.data.operation == OP_START)) begin
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_i <= PJW'(1);
                    if (r_projs == PW'(1)) begin
                        r_k     <= '0;
                        r_top   <= '0;
                        r_level <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_k     <= '0;
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (r_k == w_k_last) begin
                        r_state <= S_COMMIT;
                    end else begin
                        r_k <= r_k + LVW'(1);
                    end
                end
                S_COMMIT: begin
                    if (PW'(r_i) == r_projs - PW'(1)) begin
                        r_k     <= '0;
                        r_top   <= '0;
                        r_level <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_i     <= r_i + PJW'(1);
                        r_state <= S_LOAD;
                    end
                end
                S_SCAN: begin
                    r_top   <= w_top_nx;
                    r_level <= w_level_nx;
                    r_k     <= r_k + LVW'(1);
                    if (r_k == w_k_last) begin
                        r_left  <= w_level_nx;
                        r_bi    <= r_projs;
                        r_state <= S_BACK;
                    end
                end
                S_BACK: begin
                    if (w_slot) begin
                        r_odata.project_number <= 3'(r_bi);
                        r_odata.allocation     <= w_alloc;
                        r_odata.total_profit   <= r_top;
                        r_odata.last           <= (r_bi == PW'(1));
                        r_left                 <= r_left - LVW'(w_alloc);
                        r_bi                   <= r_bi - PW'(1);
                        if (r_bi == PW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BACK) |-> (r_left <= r_level))
        else $error("Backtrack level exceeds the chosen level.");

    a_last_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_odata.last) |-> (r_odata.project_number == 3'd1))
        else $error("Final result does not report the first project.");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (MW'(r_k) < r_levels))
        else $error("Step index beyond the money levels in use.");

    a_back_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_k == w_k_last) |=> (r_bi == r_projs))
        else $error("Backtrack did not start at the last project.");

endmodule

// ----- hdl/iad_cell.sv -----
// One money-level cell: its profit column, choice column and running best.
// Profit shifts toward higher levels, previous best toward level zero.
// Depends on iad_pkg.
module iad_cell #(
    parameter int MAX_PROJECTS = 4,
    parameter int MAX_LEVELS   = 8,
    parameter int J            = 0
) (
    input  logic                                                    i_clk,
    input  iad_pkg::t_cell_ctl                                      i_ctl,
    input  logic [((MAX_PROJECTS > 1) ? $clog2(MAX_PROJECTS) : 1)-1:0] i_proj,
    input  logic [((MAX_PROJECTS > 1) ? $clog2(MAX_PROJECTS) : 1)-1:0] i_rd_proj,
    input  logic [2:0]                                              i_wr_lvl,
    input  logic [iad_pkg::PROFIT_W-1:0]                            i_wr_data,
    input  logic [$clog2(MAX_LEVELS)-1:0]                           i_k,
    input  logic [$clog2(MAX_LEVELS)-1:0]                           i_left,
    input  logic [iad_pkg::BEST_W-1:0]                              i_head,
    input  logic [iad_pkg::PROFIT_W-1:0]                            i_sh,
    output logic [iad_pkg::PROFIT_W-1:0]                            o_sh,
    input  logic [iad_pkg::BEST_W-1:0]                              i_prev,
    output logic [iad_pkg::BEST_W-1:0]                              o_prev,
    output logic [iad_pkg::ALLOC_W-1:0]                             o_choice
);
    import iad_pkg::*;

    localparam int LVW = $clog2(MAX_LEVELS);

    logic [PROFIT_W-1:0] r_col [MAX_PROJECTS];
    logic [ALLOC_W-1:0]  r_choice [MAX_PROJECTS];
    logic [PROFIT_W-1:0] r_sh;
    logic [BEST_W-1:0]   r_prev;
    logic [BEST_W-1:0]   r_best;
    logic [ALLOC_W-1:0]  r_tag;
    logic [BEST_W:0]     w_sum;
    logic [BEST_W-1:0]   w_sat;
    logic [LVW-1:0]      w_diff;

    assign w_sum  = {1'b0, i_head} + (BEST_W + 1)'(r_sh);
    assign w_sat  = w_sum[BEST_W] ? {BEST_W{1'b1}} : w_sum[BEST_W-1:0];
    assign w_diff = LVW'(J) - i_k;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_prof && (int'(i_wr_lvl) == J)) begin
            r_col[i_proj] <= i_wr_data;
        end
        if (i_ctl.init) begin
            r_prev      <= BEST_W'(r_col[0]);
            r_choice[0] <= ALLOC_W'(J);
        end
        if (i_ctl.load) begin
            r_sh   <= r_col[i_proj];
            r_best <= '0;
            r_tag  <= '0;
        end
        if (i_ctl.step) begin
            r_sh <= i_sh;
            if ((int'(i_k) <= J) && (w_sat > r_best)) begin
                r_best <= w_sat;
                r_tag  <= ALLOC_W'(w_diff);
            end
        end
        if (i_ctl.shift) begin
            r_prev <= i_prev;
        end
        if (i_ctl.commit) begin
            r_prev           <= r_best;
            r_choice[i_proj] <= r_tag;
        end
    end

    assign o_sh     = r_sh;
    assign o_prev   = r_prev;
    assign o_choice = (int'(i_left) == J) ? r_choice[i_rd_proj] : '0;

endmodule
